[design/lcdt_pkg.sv]
package lcdt_pkg;

  localparam logic [8:0] DOTS_PER_LINE     = 9'd456;
  localparam logic [8:0] OAM_END_DOT       = 9'd80;
  localparam logic [8:0] DRAW_END_DOT      = 9'd252;
  localparam logic [7:0] VBLANK_FIRST_LINE = 8'd144;
  localparam logic [7:0] LAST_LINE         = 8'd153;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  localparam logic ACT_TICK    = 1'b0;
  localparam logic ACT_RECHECK = 1'b1;

  localparam int EN_HBLANK  = 0;
  localparam int EN_VBLANK  = 1;
  localparam int EN_OAM     = 2;
  localparam int EN_COMPARE = 3;

  typedef struct packed {
    logic [8:0] dot;
    logic [7:0] line;
    logic [1:0] mode;
    logic       irq_prev;
    logic       cmp;
  } lcdt_state_t;

  typedef struct packed {
    logic [7:0] line_count;
    logic [1:0] mode;
    logic       coincidence;
    logic       stat_irq;
    logic       vblank_irq;
    logic       draw_line;
  } lcdt_result_t;

  localparam lcdt_state_t STATE_RESET = '{
    dot: 9'd0, line: 8'd0, mode: MODE_OAM, irq_prev: 1'b0, cmp: 1'b0
  };

endpackage

[design/lcdt_step.sv]
module lcdt_step (
  input  lcdt_pkg::lcdt_state_t  state,
  input  logic                   action,
  input  logic                   lcd_enable,
  input  logic [3:0]             stat_enables,
  input  logic [7:0]             lyc,
  output lcdt_pkg::lcdt_state_t  state_nxt,
  output lcdt_pkg::lcdt_result_t result
);
  import lcdt_pkg::*;

  logic       eval;
  logic       vb_pulse;
  logic       draw_pulse;
  logic       stat_pulse;
  logic       cmp;
  logic       high;
  logic [8:0] dot_inc;
  logic [7:0] line_inc;
  lcdt_state_t nxt;

  assign dot_inc  = state.dot + 9'd1;
  assign line_inc = state.line + 8'd1;

  always_comb begin
    nxt        = state;
    eval       = 1'b0;
    vb_pulse   = 1'b0;
    draw_pulse = 1'b0;
    if (action == ACT_RECHECK) begin
      eval = lcd_enable;
    end else if (!lcd_enable) begin
      nxt.dot      = '0;
      nxt.line     = '0;
      nxt.mode     = MODE_HBLANK;
      nxt.irq_prev = 1'b0;
    end else begin
      nxt.dot = dot_inc;
      unique case (state.mode)
        MODE_HBLANK: begin
          if (dot_inc >= DOTS_PER_LINE) begin
            nxt.dot  = '0;
            nxt.line = line_inc;
            eval     = 1'b1;
            if (line_inc == VBLANK_FIRST_LINE) begin
              nxt.mode = MODE_VBLANK;
              vb_pulse = 1'b1;
            end else begin
              nxt.mode = MODE_OAM;
            end
          end
        end
        MODE_VBLANK: begin
          if (dot_inc >= DOTS_PER_LINE) begin
            nxt.dot  = '0;
            nxt.line = line_inc;
            eval     = 1'b1;
            if (line_inc > LAST_LINE) begin
              nxt.line = '0;
              nxt.mode = MODE_OAM;
            end
          end
        end
        MODE_OAM: begin
          if (dot_inc >= OAM_END_DOT) begin
            nxt.mode = MODE_DRAW;
            eval     = 1'b1;
          end
        end
        MODE_DRAW: begin
          if (dot_inc >= DRAW_END_DOT) begin
            nxt.mode   = MODE_HBLANK;
            draw_pulse = 1'b1;
            eval       = 1'b1;
          end
        end
      endcase
    end
  end

  // status line evaluated on the updated line and mode
  always_comb begin
    cmp  = (nxt.line == lyc);
    high = (stat_enables[EN_COMPARE] && cmp) ||
           (stat_enables[EN_OAM] && nxt.mode == MODE_OAM) ||
           (stat_enables[EN_VBLANK] && nxt.mode == MODE_VBLANK) ||
           (stat_enables[EN_HBLANK] && nxt.mode == MODE_HBLANK);
    stat_pulse = eval && high && !nxt.irq_prev;
    state_nxt  = nxt;
    if (eval) begin
      state_nxt.cmp      = cmp;
      state_nxt.irq_prev = high;
    end
  end

  always_comb begin
    result.line_count  = state_nxt.line;
    result.mode        = state_nxt.mode;
    result.coincidence = state_nxt.cmp;
    result.stat_irq    = stat_pulse;
    result.vblank_irq  = vb_pulse;
    result.draw_line   = draw_pulse;
  end

endmodule

[design/lcd_mode_timing_stat_irq_top.sv]
// an accepted item passes the input register, then the output register, on its way to out_tvalid
// throughput: one item per cycle while out_tready is high, set by the sequencer update
// an input register and an output register part the two sides, so one more
// item is taken while a result waits
// reset: synchronous active-low rst_n, line 0, dot 0, OAM scan, flags clear
module lcd_mode_timing_stat_irq_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // lcd_enable, stat_enables[3:0], lyc[7:0], zero pad
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // line_count[7:0], mode[1:0], coincidence,
                                  // stat_irq, vblank_irq, draw_line, zero pad
);
  import lcdt_pkg::*;

  logic         in_valid_r;
  logic         act_r;
  logic         en_r;
  logic [3:0]   enables_r;
  logic [7:0]   lyc_r;
  lcdt_state_t  state_r;
  lcdt_state_t  state_nxt;
  lcdt_result_t res_nxt;
  lcdt_result_t res_r;
  logic         out_valid_r;
  logic         advance;
  logic         in_fire;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  lcdt_step u_step (
    .state        (state_r),
    .action       (act_r),
    .lcd_enable   (en_r),
    .stat_enables (enables_r),
    .lyc          (lyc_r),
    .state_nxt    (state_nxt),
    .result       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r     <= in_tuser;
      en_r      <= in_tdata[0];
      enables_r <= in_tdata[4:1];
      lyc_r     <= in_tdata[12:5];
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r.draw_line, res_r.vblank_irq, res_r.stat_irq,
                       res_r.coincidence, res_r.mode, res_r.line_count};

  a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.vblank_irq) |->
      (res_r.line_count == VBLANK_FIRST_LINE && res_r.mode == MODE_VBLANK))
    else $error("vblank request off its line");

  a_draw_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.draw_line) |-> (res_r.mode == MODE_HBLANK))
    else $error("draw pulse without hblank entry");

  a_visible_modes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_DRAW || state_r.mode == MODE_OAM) |->
      (state_r.line < VBLANK_FIRST_LINE))
    else $error("drawing mode during vblank lines");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("sequencer state moved without an item");

endmodule
